>>> hw/rtl/gbw_pkg.sv
package gbw_pkg;

    localparam int RADIUS    = 2;
    localparam int SPAN      = 2 * RADIUS + 1;
    localparam int LINES     = 2 * RADIUS;
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_ROWS  = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 24;
    localparam int WGT_W     = 16;
    localparam int PROD_W    = 8 + WGT_W;
    localparam int ROWSUM_W  = PROD_W + $clog2(SPAN);
    localparam int SUM_W     = ROWSUM_W + $clog2(SPAN);
    localparam int NUM_WGT   = 6;
    localparam int SAT_MAX   = 255;

    // configuration register indexes
    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_W_CENTER  = 3'd2;
    localparam logic [2:0] REG_W_DIAG_TWO = 3'd7;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [9:0]  out_column;
        logic [11:0] out_row;
        logic        frame_last;
    } t_pix_out;

    typedef struct packed {
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] g;
        logic [PROD_W-1:0] b;
    } t_prod;

    typedef logic [LINES*PIX_W-1:0] t_line_word;

    // distance class of a window position, index into the weight registers
    function automatic logic [2:0] weight_class(input int r, input int c);
        int a;
        int b;
        int lo;
        int hi;
        a  = (r < RADIUS) ? RADIUS - r : r - RADIUS;
        b  = (c < RADIUS) ? RADIUS - c : c - RADIUS;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (lo == 0) begin
            return (hi == 0) ? 3'd0 : ((hi == 1) ? 3'd1 : 3'd2);
        end else if (lo == 1) begin
            return (hi == 1) ? 3'd3 : 3'd4;
        end
        return 3'd5;
    endfunction

endpackage

>>> hw/rtl/gaussian_blur_rgb_window.sv
// throughput: one item per cycle; the whole pipeline holds only while a result
// waits in the output register and the output side stalls
// reset: synchronous active low; clears counters, valid bits and config to defaults
// line store and window hold no reset value and are filled by the pixel stream
module gaussian_blur_rgb_window import gbw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pix_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_pix_out    o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    typedef struct packed {
        logic        keep;
        logic [9:0]  column;
        logic [11:0] row;
        logic        last;
    } t_meta;

    logic [10:0]      r_width;
    logic [12:0]      r_height;
    logic [WGT_W-1:0] r_weight [NUM_WGT];

    logic [9:0]  r_col;
    logic [11:0] r_row;

    logic en;
    logic acc;
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic col_end;
    logic row_end;
    t_meta n_meta;

    logic             r_v1, r_v2, r_v3, r_v4, r_ov;
    t_meta            r_m1, r_m2, r_m3, r_m4;
    logic [PIX_W-1:0] r_pix1;
    logic [9:0]       r_col1;
    t_line_word       rd_word;
    t_line_word       wr_word;
    logic [PIX_W-1:0] vec [SPAN];

    logic [PIX_W-1:0] cell_pix  [SPAN][SPAN];
    t_prod            cell_prod [SPAN][SPAN];

    logic [ROWSUM_W-1:0] n_rs_r [SPAN];
    logic [ROWSUM_W-1:0] n_rs_g [SPAN];
    logic [ROWSUM_W-1:0] n_rs_b [SPAN];
    logic [ROWSUM_W-1:0] r_rs_r [SPAN];
    logic [ROWSUM_W-1:0] r_rs_g [SPAN];
    logic [ROWSUM_W-1:0] r_rs_b [SPAN];
    logic [SUM_W-1:0]    n_sum_r, n_sum_g, n_sum_b;
    t_pix_out            r_out;

    function automatic logic [7:0] sat(input logic [SUM_W-1:0] s);
        logic [SUM_W-17:0] v;
        v = s[SUM_W-1:16];
        return (v > (SUM_W-16)'(SAT_MAX)) ? 8'(SAT_MAX) : v[7:0];
    endfunction

    assign en         = !(r_ov && i_out_stall);
    assign acc        = i_in_valid && en;
    assign o_in_stall = !en;

    always_comb begin
        if (r_width == 11'd0) begin
            w_eff = 11'd1;
        end else if (r_width > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == 13'd0) begin
            h_eff = 13'd1;
        end else if (r_height > 13'(MAX_ROWS)) begin
            h_eff = 13'(MAX_ROWS);
        end else begin
            h_eff = r_height;
        end
        col_end = ({1'b0, r_col} + 11'd1) >= w_eff;
        row_end = ({1'b0, r_row} + 13'd1) >= h_eff;
        n_meta.keep   = (r_col >= 10'(LINES)) && (r_row >= 12'(LINES))
                        && ({1'b0, r_col} < w_eff) && ({1'b0, r_row} < h_eff);
        n_meta.column = r_col - 10'(RADIUS);
        n_meta.row    = r_row - 12'(RADIUS);
        n_meta.last   = col_end && row_end;
    end

    // configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 11'd640;
            r_height    <= 13'd480;
            r_weight[0] <= 16'd10430;
            r_weight[1] <= 16'd6326;
            r_weight[2] <= 16'd1412;
            r_weight[3] <= 16'd3837;
            r_weight[4] <= 16'd856;
            r_weight[5] <= 16'd191;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WIDTH) begin
                    r_width <= i_cfg_data[10:0];
                end else if (i_cfg_idx == REG_HEIGHT) begin
                    r_height <= i_cfg_data[12:0];
                end else if (i_cfg_idx >= REG_W_CENTER && i_cfg_idx <= REG_W_DIAG_TWO) begin
                    r_weight[3'(i_cfg_idx - REG_W_CENTER)] <= i_cfg_data;
                end
            end
            if (acc) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + 12'd1;
                end else begin
                    r_col <= r_col + 10'd1;
                end
            end
        end
    end

    gbw_line_store u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (r_col[ADDR_W-1:0]),
        .o_rd_data (rd_word),
        .i_wr_en   (en && r_v1),
        .i_wr_addr (r_col1[ADDR_W-1:0]),
        .i_wr_data (wr_word)
    );

    // vertical column, oldest row first; lines move up by one
    always_comb begin
        for (int r = 0; r < LINES; r++) begin
            vec[r] = rd_word[r*PIX_W +: PIX_W];
        end
        vec[LINES] = r_pix1;
        for (int r = 0; r < LINES; r++) begin
            wr_word[r*PIX_W +: PIX_W] = vec[r+1];
        end
    end

    for (genvar r = 0; r < SPAN; r++) begin : g_row
        for (genvar c = 0; c < SPAN; c++) begin : g_col
            gbw_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (en && r_v1),
                .i_cap    (en),
                .i_pix    ((c == SPAN-1) ? vec[r] : cell_pix[r][(c+1)%SPAN]),
                .i_weight (r_weight[weight_class(r, c)]),
                .o_pix    (cell_pix[r][c]),
                .o_prod   (cell_prod[r][c])
            );
        end
    end

    always_comb begin
        for (int r = 0; r < SPAN; r++) begin
            n_rs_r[r] = '0;
            n_rs_g[r] = '0;
            n_rs_b[r] = '0;
            for (int c = 0; c < SPAN; c++) begin
                n_rs_r[r] = n_rs_r[r] + ROWSUM_W'(cell_prod[r][c].r);
                n_rs_g[r] = n_rs_g[r] + ROWSUM_W'(cell_prod[r][c].g);
                n_rs_b[r] = n_rs_b[r] + ROWSUM_W'(cell_prod[r][c].b);
            end
        end
        n_sum_r = '0;
        n_sum_g = '0;
        n_sum_b = '0;
        for (int r = 0; r < SPAN; r++) begin
            n_sum_r = n_sum_r + SUM_W'(r_rs_r[r]);
            n_sum_g = n_sum_g + SUM_W'(r_rs_g[r]);
            n_sum_b = n_sum_b + SUM_W'(r_rs_b[r]);
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4 && r_m4.keep;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_in_valid) begin
                r_pix1 <= i_in_data;
                r_col1 <= r_col;
                r_m1   <= n_meta;
            end
            r_m2   <= r_m1;
            r_m3   <= r_m2;
            r_m4   <= r_m3;
            r_rs_r <= n_rs_r;
            r_rs_g <= n_rs_g;
            r_rs_b <= n_rs_b;
            r_out.red_out    <= sat(n_sum_r);
            r_out.green_out  <= sat(n_sum_g);
            r_out.blue_out   <= sat(n_sum_b);
            r_out.out_column <= r_m4.column;
            r_out.out_row    <= r_m4.row;
            r_out.frame_last <= r_m4.last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/gbw_line_store.sv
module gbw_line_store import gbw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_line_word        o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_line_word        i_wr_data
);

    t_line_word r_mem [MAX_WIDTH];
    t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/gbw_cell.sv
module gbw_cell import gbw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic             i_cap,
    input  logic [PIX_W-1:0] i_pix,
    input  logic [WGT_W-1:0] i_weight,
    output logic [PIX_W-1:0] o_pix,
    output t_prod            o_prod
);

    logic [PIX_W-1:0] r_pix;
    t_prod            r_prod;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pix <= i_pix;
        end
        if (i_cap) begin
            r_prod.r <= r_pix[23:16] * i_weight;
            r_prod.g <= r_pix[15:8] * i_weight;
            r_prod.b <= r_pix[7:0] * i_weight;
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule
